// ===== design/rbc_pkg.sv =====
// Shared constants, types and helper functions for the radix base converter.
`default_nettype none
package rbc_pkg;
    localparam int OUT_DIGITS_DEF = 64;
    localparam int BASE_W  = 12;
    localparam int DIGIT_W = 11;
    localparam int VAL_W   = 24;
    localparam int CFG_IDX_W = 2;
    localparam int TDATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_INPUT_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_BASE = 2'd1;

    localparam logic [BASE_W-1:0] BASE_MIN = 12'd2;
    localparam logic [BASE_W-1:0] BASE_MAX = 12'd2048;

    // divider result handed back to the sequencer
    typedef struct packed {
        logic             done;
        logic             busy;
        logic [VAL_W-1:0] quot;
        logic [BASE_W-1:0] rem;
    } div_stat_t;

    function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
        logic [BASE_W-1:0] r;
        r = b;
        if (b < BASE_MIN) r = BASE_MIN;
        else if (b > BASE_MAX) r = BASE_MAX;
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== design/radix_base_converter.sv =====
// Radix base converter top level: sequencer, digit store and divider.
// Per input digit: OUT_DIGITS carry steps, each a store read, a multiply-add and a serial
// divide by the output base; on the last digit, the output digits follow, most significant
// first, each held in the output register until it is taken downstream.
// One item is in work at a time. Synchronous active-low reset restores the base
// registers to 256 and 58 and marks the store empty (reads as zero), overflow cleared.
`default_nettype none
module radix_base_converter #(
    parameter int OUT_DIGITS = rbc_pkg::OUT_DIGITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [rbc_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [rbc_pkg::BASE_W-1:0]    cfg_wdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [rbc_pkg::TDATA_W-1:0]   s_tdata,  // [10:0] digit_in
    input  wire logic                          s_tlast,  // last_in
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [rbc_pkg::TDATA_W-1:0]   m_tdata,  // [10:0] digit_out
    output logic                               m_tlast,  // last_out
    output logic                               m_tuser   // overflow
);
    localparam int IDX_W = (OUT_DIGITS > 1) ? $clog2(OUT_DIGITS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(OUT_DIGITS - 1);

    typedef enum logic [2:0] {
        IDLE, LOAD, MULADD, DIVIDE, EMIT_RD, EMIT_LD, EMIT_HOLD
    } state_t;

    state_t                       state_reg, state_next;
    logic [IDX_W-1:0]             idx_reg, idx_next, top_reg, top_next;
    logic [rbc_pkg::VAL_W-1:0]    carry_reg, carry_next;
    logic                         last_reg, last_next, ovf_reg, ovf_next;
    logic [rbc_pkg::BASE_W-1:0]   in_base_reg, out_base_reg;
    logic [rbc_pkg::DIGIT_W-1:0]  odata_reg, odata_next;
    logic                         olast_reg, olast_next, ovalid_reg, ovalid_next;
    logic                         oovf_reg, oovf_next;

    logic                         wr_en;
    logic [rbc_pkg::DIGIT_W-1:0]  wr_data, rd_data;
    logic                         div_start;
    logic [rbc_pkg::VAL_W-1:0]    mac;
    rbc_pkg::div_stat_t           dstat;

    rbc_store #(.OUT_DIGITS(OUT_DIGITS)) u_store (
        .aclk(aclk), .aresetn(aresetn),
        .wr_en(wr_en), .wr_addr(idx_reg), .wr_data(wr_data),
        .rd_addr(idx_reg), .rd_data(rd_data)
    );

    assign mac = (rbc_pkg::VAL_W'(rd_data)
                  * rbc_pkg::VAL_W'(rbc_pkg::clamp_base(in_base_reg))) + carry_reg;

    rbc_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(mac),
        .divisor(rbc_pkg::clamp_base(out_base_reg)), .stat(dstat)
    );

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        top_next    = top_reg;
        carry_next  = carry_reg;
        last_next   = last_reg;
        ovf_next    = ovf_reg;
        odata_next  = odata_reg;
        olast_next  = olast_reg;
        oovf_next   = oovf_reg;
        ovalid_next = ovalid_reg;
        wr_en       = 1'b0;
        wr_data     = '0;
        div_start   = 1'b0;
        unique case (state_reg)
            IDLE: begin
                if (s_tvalid) begin
                    carry_next = rbc_pkg::VAL_W'(s_tdata[rbc_pkg::DIGIT_W-1:0]);
                    last_next  = s_tlast;
                    idx_next   = '0;
                    top_next   = '0;
                    state_next = LOAD;
                end
            end
            LOAD:   state_next = MULADD;
            MULADD: begin
                div_start  = 1'b1;
                state_next = DIVIDE;
            end
            DIVIDE: begin
                if (dstat.done) begin
                    wr_en      = 1'b1;
                    wr_data    = dstat.rem[rbc_pkg::DIGIT_W-1:0];
                    carry_next = dstat.quot;
                    if (dstat.rem != '0) top_next = idx_reg;
                    if (idx_reg == IDX_LAST) begin
                        if (dstat.quot != '0) ovf_next = 1'b1;
                        idx_next   = (dstat.rem != '0) ? idx_reg : top_reg;
                        state_next = last_reg ? EMIT_RD : IDLE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = LOAD;
                    end
                end
            end
            EMIT_RD: state_next = EMIT_LD;
            EMIT_LD: begin
                // hand the digit out and clear its entry
                odata_next  = rd_data;
                olast_next  = (idx_reg == '0);
                oovf_next   = ovf_reg;
                ovalid_next = 1'b1;
                wr_en       = 1'b1;
                state_next  = EMIT_HOLD;
            end
            EMIT_HOLD: begin
                if (m_tready) begin
                    ovalid_next = 1'b0;
                    if (idx_reg == '0) begin
                        ovf_next   = 1'b0;
                        state_next = IDLE;
                    end else begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = EMIT_RD;
                    end
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= IDLE;
            ovf_reg      <= 1'b0;
            ovalid_reg   <= 1'b0;
            in_base_reg  <= 12'd256;
            out_base_reg <= 12'd58;
        end else begin
            state_reg  <= state_next;
            ovf_reg    <= ovf_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we) begin
                unique case (cfg_addr)
                    rbc_pkg::REG_INPUT_BASE:  in_base_reg  <= cfg_wdata;
                    rbc_pkg::REG_OUTPUT_BASE: out_base_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
        idx_reg   <= idx_next;
        top_reg   <= top_next;
        carry_reg <= carry_next;
        last_reg  <= last_next;
        odata_reg <= odata_next;
        olast_reg <= olast_next;
        oovf_reg  <= oovf_next;
    end

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = rbc_pkg::TDATA_W'(odata_reg);
    assign m_tlast  = olast_reg;
    assign m_tuser  = oovf_reg;

    // no input is taken while a digit is on offer
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("input ready while output pending");
    // divider is never started while busy
    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !dstat.busy) else $error("divider restarted while busy");
    // a result is only offered from the hold state
    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> state_reg == EMIT_HOLD) else $error("stray output valid");
    // final digit ends emission
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready) else $error("no return to idle");
endmodule
`default_nettype wire

// ===== design/rbc_store.sv =====
// Output digit store: one write port, one registered read port, per-entry valid bits.
`default_nettype none
module rbc_store #(
    parameter int OUT_DIGITS = rbc_pkg::OUT_DIGITS_DEF,
    localparam int IDX_W = (OUT_DIGITS > 1) ? $clog2(OUT_DIGITS) : 1
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        wr_en,
    input  wire logic [IDX_W-1:0]            wr_addr,
    input  wire logic [rbc_pkg::DIGIT_W-1:0] wr_data,
    input  wire logic [IDX_W-1:0]            rd_addr,
    output logic      [rbc_pkg::DIGIT_W-1:0] rd_data
);
    logic [rbc_pkg::DIGIT_W-1:0] mem [OUT_DIGITS];
    logic [OUT_DIGITS-1:0]       valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        // unwritten entries read as zero
        rd_data <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end
endmodule
`default_nettype wire

// ===== design/rbc_divider.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module rbc_divider (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [rbc_pkg::VAL_W-1:0]  dividend,
    input  wire logic [rbc_pkg::BASE_W-1:0] divisor,
    output rbc_pkg::div_stat_t              stat
);
    localparam int CNT_W = $clog2(rbc_pkg::VAL_W + 1);

    logic [CNT_W-1:0]            cnt_reg;
    logic                        busy_reg, done_reg;
    logic [rbc_pkg::VAL_W-1:0]   quo_reg;
    logic [rbc_pkg::BASE_W-1:0]  rem_reg, dvs_reg;
    logic [rbc_pkg::BASE_W:0]    trial;
    logic                        ge;

    assign trial = {rem_reg, quo_reg[rbc_pkg::VAL_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(rbc_pkg::VAL_W);
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg <= ge ? rbc_pkg::BASE_W'(trial - {1'b0, dvs_reg})
                              : trial[rbc_pkg::BASE_W-1:0];
                quo_reg <= {quo_reg[rbc_pkg::VAL_W-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.done = done_reg;
    assign stat.busy = busy_reg;
    assign stat.quot = quo_reg;
    assign stat.rem  = rem_reg;
endmodule
`default_nettype wire

// ===== sim/radix_base_converter_checker.sv =====
// Checker for the radix base converter: watches both streams, predicts and compares digits.
`timescale 1ns / 100ps
module radix_base_converter_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [rbc_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [rbc_pkg::BASE_W-1:0]    cfg_wdata,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic [rbc_pkg::TDATA_W-1:0]   s_tdata,
    input  wire logic                          s_tlast,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [rbc_pkg::TDATA_W-1:0]   m_tdata,
    input  wire logic                          m_tlast,
    input  wire logic                          m_tuser,
    output int                                 fail_count,
    output int                                 pending_digits
);
    typedef struct packed {
        logic [rbc_pkg::DIGIT_W-1:0] digit;
        logic                        last;
        logic                        ovf;
    } out_digit_t;

    localparam int NDIG = rbc_pkg::OUT_DIGITS_DEF;
    localparam int DW   = rbc_pkg::DIGIT_W;

    logic [rbc_pkg::BASE_W-1:0] in_radix, out_radix;
    logic [DW-1:0]              acc_digits [NDIG];
    logic                       carry_lost;
    out_digit_t                 expected_digits [$];

    function automatic logic [rbc_pkg::BASE_W-1:0] limit_radix(
            logic [rbc_pkg::BASE_W-1:0] b);
        if (b < 12'd2) return 12'd2;
        if (b > 12'd2048) return 12'd2048;
        return b;
    endfunction

    // multiply-add-divide pass, then emission on the final digit
    task automatic convert_digit(input logic [DW-1:0] d, input logic fin);
        longint unsigned mul, dv, carry, v;
        int top;
        out_digit_t e;
        mul = limit_radix(in_radix);
        dv = limit_radix(out_radix);
        carry = d;
        for (int i = 0; i < NDIG; i++) begin
            v = acc_digits[i] * mul + carry;
            acc_digits[i] = DW'(v % dv);
            carry = v / dv;
        end
        if (carry != 0) carry_lost = 1'b1;
        if (fin) begin
            top = NDIG - 1;
            while (top > 0 && acc_digits[top] == 0) top--;
            for (int i = top; i >= 0; i--) begin
                e.digit = acc_digits[i];
                e.last = (i == 0);
                e.ovf = carry_lost;
                expected_digits.push_back(e);
            end
            for (int i = 0; i < NDIG; i++) acc_digits[i] = '0;
            carry_lost = 1'b0;
        end
    endtask

    assign pending_digits = expected_digits.size();

    always @(posedge aclk) begin
        out_digit_t e;
        if (!aresetn) begin
            in_radix <= 12'd256;
            out_radix <= 12'd58;
            for (int i = 0; i < NDIG; i++) acc_digits[i] = '0;
            carry_lost = 1'b0;
            expected_digits.delete();
            fail_count <= 0;
        end else begin
            if (cfg_we) begin
                if (cfg_addr == rbc_pkg::REG_INPUT_BASE) in_radix <= cfg_wdata;
                else if (cfg_addr == rbc_pkg::REG_OUTPUT_BASE) out_radix <= cfg_wdata;
            end
            if (s_tvalid && s_tready) convert_digit(s_tdata[DW-1:0], s_tlast);
            if (m_tvalid && m_tready) begin
                if (expected_digits.size() == 0) begin
                    $error("unexpected output transaction: digit %0d", m_tdata[DW-1:0]);
                    fail_count <= fail_count + 1;
                end else begin
                    e = expected_digits.pop_front();
                    if (m_tdata[DW-1:0] !== e.digit || m_tlast !== e.last
                            || m_tuser !== e.ovf) begin
                        if (m_tdata[DW-1:0] !== e.digit)
                            $error("digit_out expected %0d got %0d", e.digit,
                                   m_tdata[DW-1:0]);
                        if (m_tlast !== e.last)
                            $error("last_out expected %0d got %0d", e.last, m_tlast);
                        if (m_tuser !== e.ovf)
                            $error("overflow expected %0d got %0d", e.ovf, m_tuser);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== sim/radix_base_converter_test.sv =====
// Testbench top for the radix base converter: stimulus, idling, watchdog and verdict.
`timescale 1ns / 100ps
module radix_base_converter_test;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int DW = rbc_pkg::DIGIT_W;
    localparam int BW = rbc_pkg::BASE_W;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [rbc_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
    logic [BW-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0, s_tready, s_tlast = 1'b0;
    logic [rbc_pkg::TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid, m_tready = 1'b0, m_tlast, m_tuser;
    logic [rbc_pkg::TDATA_W-1:0] m_tdata;
    int fail_count, pending_digits;
    int send_idle_pct = 31, recv_idle_pct = 75;
    int quiet_cycles = 0;

    always #4 aclk = ~aclk;

    radix_base_converter u_top (
        .aclk, .aresetn, .cfg_we, .cfg_addr, .cfg_wdata,
        .s_tvalid, .s_tready, .s_tdata, .s_tlast,
        .m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser
    );

    radix_base_converter_checker u_check (
        .aclk, .aresetn, .cfg_we, .cfg_addr, .cfg_wdata,
        .s_tvalid, .s_tready, .s_tdata, .s_tlast,
        .m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser,
        .fail_count, .pending_digits
    );

    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // valid drops between transactions
    task automatic send_digit(input logic [DW-1:0] d, input logic fin);
        do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        s_tvalid <= 1'b1;
        s_tdata <= rbc_pkg::TDATA_W'(d);
        s_tlast <= fin;
        do @(posedge aclk); while (!s_tready);
        s_tvalid <= 1'b0;
    endtask

    // wait until the block is idle with the store drained before a register write
    task automatic drain();
        do @(posedge aclk); while (pending_digits != 0 || !s_tready);
        repeat (40) @(posedge aclk);
    endtask

    task automatic set_radix(input logic [BW-1:0] ib, input logic [BW-1:0] ob);
        drain();
        cfg_we <= 1'b1;
        cfg_addr <= rbc_pkg::REG_INPUT_BASE;
        cfg_wdata <= ib;
        @(posedge aclk);
        cfg_addr <= rbc_pkg::REG_OUTPUT_BASE;
        cfg_wdata <= ob;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // one number of n digits below the input radix, the odd one out of range
    task automatic send_number(input int n, input int ib);
        int lim;
        lim = (ib > 2048) ? 2047 : ((ib < 2) ? 1 : ib - 1);
        for (int i = 0; i < n; i++)
            send_digit(($urandom_range(9) == 0) ? DW'($urandom)
                                               : DW'($urandom_range(lim)), i == n - 1);
    endtask

    int ib, ob;

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // reset radices: all zero, zero then nonzero, single full digit
        send_digit(11'd0, 1'b0); send_digit(11'd0, 1'b1);
        send_digit(11'd0, 1'b0); send_digit(11'd255, 1'b1);
        send_digit(11'd2047, 1'b1);
        // extremes of the radices, clamping below 2 and above 2048
        set_radix(12'd2048, 12'd2);
        send_digit(11'd2047, 1'b0); send_digit(11'd2047, 1'b1);
        set_radix(12'd0, 12'd4095);
        send_digit(11'd1, 1'b0); send_digit(11'd1, 1'b1);
        set_radix(12'd2, 12'd2048);
        send_digit(11'd1, 1'b0); send_digit(11'd0, 1'b0); send_digit(11'd1, 1'b1);
        // overflow: many large digits into a small output radix
        set_radix(12'd2048, 12'd2);
        for (int i = 0; i < 8; i++) send_digit(11'h7FF, i == 7);
        set_radix(12'd10, 12'd16);
        send_digit(11'd2047, 1'b1);
        for (int phase = 0; phase < 3; phase++) begin
            drain();
            send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 75 : 0;
            recv_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 31 : 0;
            for (int k = 0; k < 17; k++) begin
                if (k % 4 == 0) begin
                    ib = ($urandom_range(7) == 0) ? $urandom_range(4095)
                                                  : $urandom_range(2, 2048);
                    ob = ($urandom_range(7) == 0) ? $urandom_range(4095)
                                                  : $urandom_range(2, 2048);
                    set_radix(BW'(ib), BW'(ob));
                end
                send_number($urandom_range(1, 7), ib);
            end
        end
        drain();
        repeat (200) @(posedge aclk);
        if (fail_count == 0 && pending_digits == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

// ===== radix_base_converter.f =====
design/rbc_pkg.sv
design/rbc_store.sv
design/rbc_divider.sv
design/radix_base_converter.sv
sim/radix_base_converter_checker.sv
sim/radix_base_converter_test.sv
